// ===== rtl/hre_pkg.sv =====
// Package for the homography reprojection error block.
// Holds payload types, widths, the adjugate operand table and the register reset values.
// Used by every module in this folder; it depends on nothing else.
package hre_pkg;

	localparam int HOM_W      = 64;
	localparam int NREGS      = 8;
	localparam int IDX_W      = 3;
	localparam int PIXEL_BITS = 12;
	localparam int GND_W      = 32;
	localparam int ERR_W      = 48;
	localparam int ACC_W      = 2 * HOM_W + PIXEL_BITS + 4;
	localparam int QUO_W      = ACC_W + 16;
	localparam int NBITS_W    = 7;
	localparam int SEL_W      = 4;

	localparam logic [HOM_W-1:0] ONE_Q40 = HOM_W'(1) << 40;
	localparam logic [SEL_W-1:0] SEL_ONE = 4'd8;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_x;
		logic [PIXEL_BITS-1:0] pixel_y;
		logic [GND_W-1:0]      ref_x;
		logic [GND_W-1:0]      ref_y;
		logic                  last_point;
	} in_item_t;

	typedef struct packed {
		logic [GND_W-1:0] ground_x;
		logic [GND_W-1:0] ground_y;
		logic [ERR_W-1:0] error_sum;
		logic             degenerate;
		logic             run_done;
	} out_item_t;

	typedef struct packed {
		logic               start;
		logic               b_signed;
		logic               negate;
		logic [NBITS_W-1:0] nbits;
	} mac_cmd_t;

	typedef struct packed {
		logic [SEL_W-1:0] a;
		logic [SEL_W-1:0] b;
		logic [SEL_W-1:0] c;
		logic [SEL_W-1:0] d;
	} cross_ops_t;

	// Adjugate entry a*b - c*d, listed in the order the denominator row and then the
	// two numerator rows are evaluated.
	function automatic cross_ops_t cross_ops(input logic [3:0] k);
		cross_ops_t r;
		case (k)
			4'd0:    r = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'd1:    r = '{4'd1, 4'd6, 4'd0, 4'd7};
			4'd2:    r = '{4'd0, 4'd4, 4'd1, 4'd3};
			4'd3:    r = '{4'd4, SEL_ONE, 4'd5, 4'd7};
			4'd4:    r = '{4'd2, 4'd7, 4'd1, SEL_ONE};
			4'd5:    r = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'd6:    r = '{4'd5, 4'd6, 4'd3, SEL_ONE};
			4'd7:    r = '{4'd0, SEL_ONE, 4'd2, 4'd6};
			4'd8:    r = '{4'd2, 4'd3, 4'd0, 4'd5};
			default: r = '{4'd0, 4'd0, 4'd0, 4'd0};
		endcase
		return r;
	endfunction

	function automatic logic [HOM_W-1:0] hom_reset(input int i);
		return (i == 0 || i == 4) ? ONE_Q40 : '0;
	endfunction

endpackage

// ===== rtl/hre_mac.sv =====
// Bit-serial multiply-accumulate unit: acc = init +/- a * b, one multiplier bit a cycle.
// The multiplier may be unsigned or two's complement. Depends on hre_pkg.
module hre_mac #(
	parameter int W = hre_pkg::ACC_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hre_pkg::mac_cmd_t        cmd,
	input  logic [W-1:0]             a,
	input  logic [hre_pkg::HOM_W-1:0] b,
	input  logic [W-1:0]             init,
	output logic                     busy,
	output logic [W-1:0]             acc
);
	import hre_pkg::*;

	logic [W-1:0]       a_q;
	logic [HOM_W-1:0]   b_q;
	logic [W-1:0]       acc_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               busy_q;
	logic               sgn_q;
	logic               neg_q;
	logic               ne;
	logic [W-1:0]       addend;

	assign ne     = neg_q ^ (sgn_q && cnt_q == '0);
	assign addend = ne ? (~a_q + W'(1)) : a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.nbits - NBITS_W'(1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - NBITS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= init;
			sgn_q <= cmd.b_signed;
			neg_q <= cmd.negate;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + addend;
			end
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[HOM_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

// ===== rtl/hre_div.sv =====
// Restoring divider, one quotient bit a cycle, with round-half-up on the remainder.
// Operands are unsigned magnitudes. Depends on hre_pkg for its default widths.
module hre_div #(
	parameter int NW = hre_pkg::QUO_W,
	parameter int DW = hre_pkg::ACC_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW:0]   quo
);
	import hre_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   rs;
	logic [DW+1:0] diff;
	logic          rnd;

	assign rs   = {r_q, n_q[NW-1]};
	assign diff = {1'b0, rs} - {2'b00, d_q};
	assign rnd  = {r_q, 1'b0} >= {1'b0, d_q};
	assign quo  = {1'b0, q_q} + (NW + 1)'(rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			q_q <= '0;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!diff[DW+1]) begin
				r_q <= diff[DW-1:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rs[DW-1:0];
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;

endmodule

// ===== rtl/homography_reprojection_error.sv =====
// Homography reprojection error: maps a pixel through the adjugate of H and sums squared error.
// Each point runs the bit-serial multiply-accumulate unit (one multiplier bit a cycle) and, for a
// nonzero denominator, the divider twice; a zero denominator skips the division and squaring.
// in_stall holds off a new transaction until the sequencer is idle again; a stalled result delays it.
// Reset clears the accumulator, the handshakes and the sequencer; H resets to identity.
// Depends on hre_pkg, hre_mac and hre_div.
module homography_reprojection_error (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  hre_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output hre_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [hre_pkg::IDX_W-1:0]   cfg_index,
	input  logic [hre_pkg::HOM_W-1:0]   cfg_data
);
	import hre_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_LDA  = 12'b000000000010,
		ST_MULS = 12'b000000000100,
		ST_MULW = 12'b000000001000,
		ST_PXS  = 12'b000000010000,
		ST_PXW  = 12'b000000100000,
		ST_DIVS = 12'b000001000000,
		ST_DIVW = 12'b000010000000,
		ST_SQS  = 12'b000100000000,
		ST_SQW  = 12'b001000000000,
		ST_ACC  = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

	localparam logic [ERR_W-1:0] MAX48 = '1;

	state_t                state_q;
	logic [HOM_W-1:0]      hom_q [NREGS];
	logic [PIXEL_BITS-1:0] px_q, py_q;
	logic [GND_W-1:0]      rx_q, ry_q;
	logic                  last_q;
	logic [1:0]            dot_q, term_q;
	logic                  half_q;
	logic [HOM_W-1:0]      op_a_q;
	logic [ACC_W-1:0]      d_q, w_q;
	logic [GND_W-1:0]      gx_q, gy_q;
	logic                  deg_q, div_neg_q;
	logic [ERR_W-1:0]      accum_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	cross_ops_t       ops;
	logic [SEL_W-1:0] sel;
	logic [HOM_W-1:0] hom_rd;
	mac_cmd_t         mac_cmd;
	logic [ACC_W-1:0] mac_a, mac_init, mac_acc;
	logic [HOM_W-1:0] mac_b;
	logic             mac_busy;
	logic             div_start, div_busy;
	logic [ACC_W-1:0] d_abs, w_abs;
	logic [QUO_W:0]   quo;
	logic [GND_W-1:0] g_sat;
	logic [32:0]      dx, dy, dsel;
	logic [48:0]      err;
	logic [49:0]      sum;

	assign ops    = cross_ops(4'(dot_q) * 4'd3 + 4'(term_q));
	assign sel    = (state_q == ST_LDA) ? (half_q ? ops.c : ops.a) : (half_q ? ops.d : ops.b);
	assign hom_rd = (sel == SEL_ONE) ? ONE_Q40 : hom_q[sel[IDX_W-1:0]];

	assign dx   = {gx_q[GND_W-1], gx_q} - {rx_q[GND_W-1], rx_q};
	assign dy   = {gy_q[GND_W-1], gy_q} - {ry_q[GND_W-1], ry_q};
	assign dsel = half_q ? dy : dx;

	always_comb begin
		mac_cmd  = '0;
		mac_a    = {{(ACC_W-HOM_W){op_a_q[HOM_W-1]}}, op_a_q};
		mac_b    = hom_rd;
		mac_init = half_q ? mac_acc : '0;
		case (state_q)
			ST_MULS: begin
				mac_cmd = '{1'b1, 1'b1, half_q, NBITS_W'(HOM_W)};
			end
			ST_PXS: begin
				mac_a    = mac_acc;
				mac_init = d_q;
				if (term_q == 2'd0) begin
					mac_b   = HOM_W'(px_q);
					mac_cmd = '{1'b1, 1'b0, 1'b0, NBITS_W'(PIXEL_BITS)};
				end else if (term_q == 2'd1) begin
					mac_b   = HOM_W'(py_q);
					mac_cmd = '{1'b1, 1'b0, 1'b0, NBITS_W'(PIXEL_BITS)};
				end else begin
					mac_b   = HOM_W'(1);
					mac_cmd = '{1'b1, 1'b0, 1'b0, NBITS_W'(1)};
				end
			end
			ST_SQS: begin
				mac_a   = {{(ACC_W-33){dsel[32]}}, dsel};
				mac_b   = {{(HOM_W-33){dsel[32]}}, dsel};
				mac_cmd = '{1'b1, 1'b1, 1'b0, NBITS_W'(HOM_W)};
			end
			default: begin
				mac_cmd = '0;
			end
		endcase
	end

	hre_mac #(.W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mac_a),
		.b      (mac_b),
		.init   (mac_init),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	assign d_abs     = d_q[ACC_W-1] ? (~d_q + ACC_W'(1)) : d_q;
	assign w_abs     = w_q[ACC_W-1] ? (~w_q + ACC_W'(1)) : w_q;
	assign div_start = (state_q == ST_DIVS);

	hre_div #(.NW(QUO_W), .DW(ACC_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({d_abs, 16'b0}),
		.den    (w_abs),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_comb begin
		if (div_neg_q) begin
			if (quo > (QUO_W + 1)'(33'h080000000)) begin
				g_sat = 32'h80000000;
			end else begin
				g_sat = 32'(~quo[31:0] + 32'd1);
			end
		end else begin
			if (quo > (QUO_W + 1)'(32'h7fffffff)) begin
				g_sat = 32'h7fffffff;
			end else begin
				g_sat = quo[31:0];
			end
		end
	end

	assign err = mac_acc[64:16];
	assign sum = {2'b00, accum_q} + {1'b0, err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				hom_q[i] <= hom_reset(i);
			end
		end else if (cfg_we) begin
			hom_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dot_q       <= '0;
			term_q      <= '0;
			half_q      <= 1'b0;
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dot_q   <= '0;
						term_q  <= '0;
						half_q  <= 1'b0;
						state_q <= ST_LDA;
					end
				end
				ST_LDA: begin
					state_q <= ST_MULS;
				end
				ST_MULS: begin
					state_q <= ST_MULW;
				end
				ST_MULW: begin
					if (!mac_busy) begin
						half_q  <= ~half_q;
						state_q <= half_q ? ST_PXS : ST_LDA;
					end
				end
				ST_PXS: begin
					state_q <= ST_PXW;
				end
				ST_PXW: begin
					if (!mac_busy) begin
						if (term_q != 2'd2) begin
							term_q  <= term_q + 2'd1;
							state_q <= ST_LDA;
						end else begin
							term_q <= '0;
							if (dot_q == 2'd0) begin
								if (mac_acc == '0) begin
									state_q <= ST_OUT;
								end else begin
									dot_q   <= 2'd1;
									state_q <= ST_LDA;
								end
							end else begin
								state_q <= ST_DIVS;
							end
						end
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!div_busy) begin
						if (dot_q == 2'd1) begin
							dot_q   <= 2'd2;
							state_q <= ST_LDA;
						end else begin
							half_q  <= 1'b0;
							state_q <= ST_SQS;
						end
					end
				end
				ST_SQS: begin
					state_q <= ST_SQW;
				end
				ST_SQW: begin
					if (!mac_busy) begin
						half_q  <= ~half_q;
						state_q <= half_q ? ST_ACC : ST_SQS;
					end
				end
				ST_ACC: begin
					accum_q <= (sum > {2'b00, MAX48}) ? MAX48 : sum[ERR_W-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						if (last_q) begin
							accum_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= in_data.pixel_x;
				py_q   <= in_data.pixel_y;
				rx_q   <= in_data.ref_x;
				ry_q   <= in_data.ref_y;
				last_q <= in_data.last_point;
				d_q    <= '0;
				deg_q  <= 1'b0;
				gx_q   <= '0;
				gy_q   <= '0;
			end
			ST_LDA: begin
				op_a_q <= hom_rd;
			end
			ST_PXW: begin
				if (!mac_busy) begin
					if (term_q != 2'd2) begin
						d_q <= mac_acc;
					end else if (dot_q == 2'd0) begin
						w_q   <= mac_acc;
						d_q   <= '0;
						deg_q <= (mac_acc == '0);
					end else begin
						d_q <= mac_acc;
					end
				end
			end
			ST_DIVS: begin
				div_neg_q <= d_q[ACC_W-1] ^ w_q[ACC_W-1];
			end
			ST_DIVW: begin
				if (!div_busy) begin
					d_q <= '0;
					if (dot_q == 2'd1) begin
						gx_q <= g_sat;
					end else begin
						gy_q <= g_sat;
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q <= '{gx_q, gy_q, accum_q, deg_q, last_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
